@@ sv/marching_squares_cell_triangulator_defines.svh @@
// assertion macros used by the triangulator top level
`ifndef MARCHING_SQUARES_CELL_TRIANGULATOR_DEFINES_SVH
`define MARCHING_SQUARES_CELL_TRIANGULATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MSCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MSCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/msct_pkg.sv @@
`default_nettype none
package msct_pkg;

    localparam int GRID_SIDE  = 1024;
    localparam int COORD_W    = $clog2(GRID_SIDE);
    localparam int MASK_W     = 16;
    localparam int T_W        = 16;
    localparam int VERT_W     = 3;
    localparam int DIV_STAGES = T_W;
    localparam int QDEPTH     = 32;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = QPTR_W + 1;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [T_W-1:0] T_HALF = 16'h8000;
    localparam logic [T_W-1:0] T_MAX  = 16'hFFFF;

    localparam logic [CFG_ADDR_W-1:0] REG_MASK_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FILL_MIXED     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DIAG_BL_TR     = 2'd2;

    localparam logic [3:0] CASE_EMPTY = 4'd0;
    localparam logic [3:0] CASE_FULL  = 4'd15;

    localparam logic [VERT_W-1:0] V_C00 = 3'd0;
    localparam logic [VERT_W-1:0] V_C10 = 3'd1;
    localparam logic [VERT_W-1:0] V_C11 = 3'd2;
    localparam logic [VERT_W-1:0] V_C01 = 3'd3;

    typedef struct packed {
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [MASK_W-1:0]  mask_00;
        logic [MASK_W-1:0]  mask_10;
        logic [MASK_W-1:0]  mask_11;
        logic [MASK_W-1:0]  mask_01;
    } in_beat_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_cell_x;
        logic [COORD_W-1:0] out_cell_y;
        logic [VERT_W-1:0]  vert_a;
        logic [VERT_W-1:0]  vert_b;
        logic [VERT_W-1:0]  vert_c;
        logic [T_W-1:0]     t_a;
        logic [T_W-1:0]     t_b;
        logic [T_W-1:0]     t_c;
        logic               last;
    } out_beat_t;

    // classified cell waiting for the emitter
    typedef struct packed {
        logic [COORD_W-1:0]       cx;
        logic [COORD_W-1:0]       cy;
        logic [3:0]               cs;
        logic [3:0][T_W-1:0]      t;
    } cell_ent_t;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic [VERT_W-1:0] a;
        logic [VERT_W-1:0] b;
        logic [VERT_W-1:0] c;
    } tri_t;

    localparam logic [2:0] POLY_LEN [16] = '{
        3'd0, 3'd3, 3'd3, 3'd4, 3'd3, 3'd6, 3'd4, 3'd5,
        3'd3, 3'd4, 3'd6, 3'd5, 3'd4, 3'd5, 3'd5, 3'd0
    };

    localparam logic [VERT_W-1:0] POLY_TAB [16][6] = '{
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd4, 3'd7, 3'd0, 3'd0, 3'd0},
        '{3'd1, 3'd5, 3'd4, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd5, 3'd7, 3'd0, 3'd0},
        '{3'd2, 3'd6, 3'd5, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd4, 3'd5, 3'd2, 3'd6, 3'd7},
        '{3'd1, 3'd2, 3'd6, 3'd4, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd2, 3'd6, 3'd7, 3'd0},
        '{3'd3, 3'd7, 3'd6, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd4, 3'd6, 3'd3, 3'd0, 3'd0},
        '{3'd1, 3'd5, 3'd6, 3'd3, 3'd7, 3'd4},
        '{3'd0, 3'd1, 3'd5, 3'd6, 3'd3, 3'd0},
        '{3'd2, 3'd3, 3'd7, 3'd5, 3'd0, 3'd0},
        '{3'd0, 3'd4, 3'd5, 3'd2, 3'd3, 3'd0},
        '{3'd1, 3'd2, 3'd3, 3'd7, 3'd4, 3'd0},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
    };

endpackage
`default_nettype wire

@@ sv/marching_squares_cell_triangulator.sv @@
// throughput: one cell per cycle while cells give at most one triangle, else one
// triangle beat per cycle, set by the single emitter, while m_ready does not stall it
// reset: aresetn synchronous active low; clears queue, credit and output valid,
// loads threshold 32768, mixed-cell fill on, split along the 00-11 diagonal
`default_nettype none
`include "marching_squares_cell_triangulator_defines.svh"
module marching_squares_cell_triangulator
    import msct_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_beat_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_beat_t                  m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration registers
    logic [MASK_W-1:0] thr_reg;
    logic              fill_reg;
    logic              diag_reg;

    // credit: cells accepted and not yet retired from the queue
    logic [QCNT_W-1:0] credit_reg;
    logic [QCNT_W-1:0] credit_next;

    logic       accept;
    logic       push;
    cell_ent_t  push_ent;
    cell_ent_t  head;
    q_stat_t    q_stat;
    logic       pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= T_HALF;
            fill_reg <= 1'b1;
            diag_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MASK_THRESHOLD: thr_reg  <= cfg_wdata[MASK_W-1:0];
                REG_FILL_MIXED:     fill_reg <= cfg_wdata[0];
                REG_DIAG_BL_TR:     diag_reg <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    // the divider lanes never stall, so a beat is only taken when its queue slot is
    // already reserved
    assign s_ready     = (credit_reg != QCNT_W'(QDEPTH));
    assign accept      = s_valid && s_ready;
    assign credit_next = credit_reg + QCNT_W'(accept) - QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    // front: corner classification and edge interpolation
    msct_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_beat   (s_data),
        .threshold (thr_reg),
        .push      (push),
        .push_ent  (push_ent)
    );

    // decoupling queue
    msct_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_ent (push_ent),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    // back: fan triangulation and the output register
    msct_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (!q_stat.empty),
        .fill_mixed (fill_reg),
        .diag_bl_tr (diag_reg),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // queued cells are a subset of those holding credit
    `MSCT_ASSERT_NOW(a_queue_in_credit, 1'b1, q_stat.count <= credit_reg, "queue exceeds credit")
    // never more cells in flight than queue slots
    `MSCT_ASSERT_NOW(a_credit_bound, 1'b1, credit_reg <= QCNT_W'(QDEPTH), "credit overflow")
    // an accepted beat with no retirement raises the credit by one
    `MSCT_ASSERT_NEXT(a_credit_step, accept && !pop, credit_reg == $past(credit_reg) + 1'b1, "step")
    // nothing retires from an empty queue
    `MSCT_ASSERT_NOW(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")

endmodule
`default_nettype wire

@@ sv/msct_div.sv @@
`default_nettype none
// one edge lane: restoring divider, one quotient bit per stage
module msct_div
    import msct_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic [T_W-1:0] num,
    input  wire logic [T_W-1:0] den,
    input  wire logic           spec,
    input  wire logic [T_W-1:0] spec_val,
    output logic      [T_W-1:0] t
);

    logic [T_W-1:0] r_reg  [0:DIV_STAGES];
    logic [T_W-1:0] d_reg  [0:DIV_STAGES];
    logic [T_W-1:0] q_reg  [0:DIV_STAGES];
    logic           s_reg  [0:DIV_STAGES];
    logic [T_W-1:0] sv_reg [0:DIV_STAGES];

    always_ff @(posedge aclk) begin
        r_reg[0]  <= num;
        d_reg[0]  <= den;
        q_reg[0]  <= '0;
        s_reg[0]  <= spec;
        sv_reg[0] <= spec_val;
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic [T_W:0] sh;
        logic [T_W:0] diff;
        assign sh   = {r_reg[g], 1'b0};
        assign diff = sh - {1'b0, d_reg[g]};
        always_ff @(posedge aclk) begin
            if (!diff[T_W]) begin
                r_reg[g+1] <= diff[T_W-1:0];
                q_reg[g+1] <= {q_reg[g][T_W-2:0], 1'b1};
            end else begin
                r_reg[g+1] <= sh[T_W-1:0];
                q_reg[g+1] <= {q_reg[g][T_W-2:0], 1'b0};
            end
            d_reg[g+1]  <= d_reg[g];
            s_reg[g+1]  <= s_reg[g];
            sv_reg[g+1] <= sv_reg[g];
        end
    end

    assign t = s_reg[DIV_STAGES] ? sv_reg[DIV_STAGES] : q_reg[DIV_STAGES];

endmodule
`default_nettype wire

@@ sv/msct_front.sv @@
`default_nettype none
// classifies a cell and runs the division for each of its edges in its own parallel lane
module msct_front
    import msct_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire in_beat_t          in_beat,
    input  wire logic [MASK_W-1:0] threshold,
    output logic                   push,
    output cell_ent_t              push_ent
);

    logic [DIV_STAGES:0] v_reg;
    logic [COORD_W-1:0]  cx_reg [0:DIV_STAGES];
    logic [COORD_W-1:0]  cy_reg [0:DIV_STAGES];
    logic [3:0]          cs_reg [0:DIV_STAGES];

    logic [3:0]          cs;
    logic [3:0][MASK_W-1:0] m0;
    logic [3:0][MASK_W-1:0] m1;
    logic [3:0][T_W-1:0] lane_t;

    assign cs = {in_beat.mask_01 >= threshold, in_beat.mask_11 >= threshold,
                 in_beat.mask_10 >= threshold, in_beat.mask_00 >= threshold};

    // edges bottom, right, top, left: lower then upper endpoint
    assign m0 = {in_beat.mask_00, in_beat.mask_01, in_beat.mask_10, in_beat.mask_00};
    assign m1 = {in_beat.mask_01, in_beat.mask_11, in_beat.mask_11, in_beat.mask_10};

    for (genvar e = 0; e < 4; e++) begin : g_edge
        logic signed [MASK_W+1:0] num_s;
        logic signed [MASK_W+1:0] den_s;
        logic signed [MASK_W+1:0] num_a;
        logic signed [MASK_W+1:0] den_a;
        logic                     spec;
        logic [T_W-1:0]           spec_val;

        always_comb begin
            num_s = $signed({2'b00, threshold}) - $signed({2'b00, m0[e]});
            den_s = $signed({2'b00, m1[e]}) - $signed({2'b00, m0[e]});
            num_a = den_s[MASK_W+1] ? -num_s : num_s;
            den_a = den_s[MASK_W+1] ? -den_s : den_s;
            spec     = 1'b1;
            spec_val = '0;
            if (den_s == '0) begin
                spec_val = T_HALF;
            end else if (num_a[MASK_W+1] || num_a == '0) begin
                spec_val = '0;
            end else if (num_a >= den_a) begin
                spec_val = T_MAX;
            end else begin
                spec = 1'b0;
            end
        end

        msct_div u_div (
            .aclk     (aclk),
            .num      (num_a[T_W-1:0]),
            .den      (den_a[T_W-1:0]),
            .spec     (spec),
            .spec_val (spec_val),
            .t        (lane_t[e])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[DIV_STAGES-1:0], accept};
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg[0] <= in_beat.cell_x;
        cy_reg[0] <= in_beat.cell_y;
        cs_reg[0] <= cs;
        for (int i = 1; i <= DIV_STAGES; i++) begin
            cx_reg[i] <= cx_reg[i-1];
            cy_reg[i] <= cy_reg[i-1];
            cs_reg[i] <= cs_reg[i-1];
        end
    end

    assign push        = v_reg[DIV_STAGES];
    assign push_ent.cx = cx_reg[DIV_STAGES];
    assign push_ent.cy = cy_reg[DIV_STAGES];
    assign push_ent.cs = cs_reg[DIV_STAGES];
    assign push_ent.t  = lane_t;

endmodule
`default_nettype wire

@@ sv/msct_queue.sv @@
`default_nettype none
// cell queue between classifier and emitter
module msct_queue
    import msct_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire cell_ent_t push_ent,
    input  wire logic      pop,
    output cell_ent_t      head,
    output q_stat_t        stat
);

    cell_ent_t         mem [QDEPTH];
    cell_ent_t         head_reg;
    logic              hv_reg;
    logic              hv_next;
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              mem_any;
    logic              load;
    logic              take;
    logic              bypass;
    logic              wr_en;

    // head register in front of the memory; an empty memory hands the push straight over
    assign mem_any  = (cnt_reg != '0);
    assign load     = (!hv_reg || pop) && (mem_any || push);
    assign take     = load && mem_any;
    assign bypass   = load && !mem_any;
    assign wr_en    = push && !bypass;
    assign hv_next  = load || (hv_reg && !pop);
    assign cnt_next = cnt_reg + QCNT_W'(wr_en) - QCNT_W'(take);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_reg] <= push_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            head_reg <= mem[rd_reg];
        end else if (bypass) begin
            head_reg <= push_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
            hv_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (take) begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
            hv_reg  <= hv_next;
        end
    end

    assign head       = head_reg;
    assign stat.empty = !hv_reg;
    assign stat.count = cnt_reg + QCNT_W'(hv_reg);

endmodule
`default_nettype wire

@@ sv/msct_back.sv @@
`default_nettype none
// emits the triangles of the head cell, one beat per cycle while the output is free
module msct_back
    import msct_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cell_ent_t head,
    input  wire logic      head_valid,
    input  wire logic      fill_mixed,
    input  wire logic      diag_bl_tr,
    output logic           pop,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    logic [1:0]  k_reg;
    logic [1:0]  k_next;
    logic        mv_reg;
    logic        mv_next;
    out_beat_t   md_reg;
    logic [2:0]  n_tri;
    logic        out_free;
    logic        fire;
    logic        is_last;
    tri_t        tri_v;

    function automatic logic [T_W-1:0] t_of(logic [VERT_W-1:0] v,
                                            logic [3:0][T_W-1:0] t);
        return v[2] ? t[v[1:0]] : '0;
    endfunction

    always_comb begin
        case (head.cs)
            CASE_EMPTY: n_tri = 3'd0;
            CASE_FULL:  n_tri = 3'd2;
            default:    n_tri = fill_mixed ? (POLY_LEN[head.cs] - 3'd2) : 3'd0;
        endcase
    end

    always_comb begin
        if (head.cs == CASE_FULL) begin
            if (diag_bl_tr) begin
                tri_v = (k_reg == 2'd0) ? tri_t'{V_C00, V_C11, V_C10}
                                        : tri_t'{V_C00, V_C01, V_C11};
            end else begin
                tri_v = (k_reg == 2'd0) ? tri_t'{V_C00, V_C01, V_C10}
                                        : tri_t'{V_C10, V_C01, V_C11};
            end
        end else begin
            tri_v.a = POLY_TAB[head.cs][0];
            tri_v.b = POLY_TAB[head.cs][3'(k_reg) + 3'd2];
            tri_v.c = POLY_TAB[head.cs][3'(k_reg) + 3'd1];
        end
    end

    assign out_free = !mv_reg || m_ready;
    assign is_last  = ({1'b0, k_reg} == n_tri - 3'd1);
    assign fire     = head_valid && (n_tri != '0) && out_free;
    assign pop      = head_valid && ((n_tri == '0) || (out_free && is_last));

    always_comb begin
        k_next = k_reg;
        if (pop) begin
            k_next = '0;
        end else if (fire) begin
            k_next = k_reg + 2'd1;
        end
        mv_next = fire ? 1'b1 : (m_ready ? 1'b0 : mv_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg  <= '0;
            mv_reg <= 1'b0;
        end else begin
            k_reg  <= k_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            md_reg.out_cell_x <= head.cx;
            md_reg.out_cell_y <= head.cy;
            md_reg.vert_a     <= tri_v.a;
            md_reg.vert_b     <= tri_v.b;
            md_reg.vert_c     <= tri_v.c;
            md_reg.t_a        <= t_of(tri_v.a, head.t);
            md_reg.t_b        <= t_of(tri_v.b, head.t);
            md_reg.t_c        <= t_of(tri_v.c, head.t);
            md_reg.last       <= is_last;
        end
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none
module tb_top;
    import msct_pkg::*;

    // vertex codes: corners from the package, edge points local
    localparam logic [VERT_W-1:0] EB = 3'd4;  // bottom edge, 00-10
    localparam logic [VERT_W-1:0] ER = 3'd5;  // right edge, 10-11
    localparam logic [VERT_W-1:0] ET = 3'd6;  // top edge, 01-11
    localparam logic [VERT_W-1:0] EL = 3'd7;  // left edge, 00-01
    localparam logic [VERT_W-1:0] C0 = V_C00;
    localparam logic [VERT_W-1:0] C1 = V_C10;
    localparam logic [VERT_W-1:0] C2 = V_C11;
    localparam logic [VERT_W-1:0] C3 = V_C01;

    // outline of each corner pattern, walked in order
    localparam int OUTLINE_LEN [16] = '{0, 3, 3, 4, 3, 6, 4, 5, 3, 4, 6, 5, 4, 5, 5, 0};
    localparam logic [VERT_W-1:0] OUTLINE [16][6] = '{
        '{C0, C0, C0, C0, C0, C0},
        '{C0, EB, EL, C0, C0, C0},
        '{C1, ER, EB, C0, C0, C0},
        '{C0, C1, ER, EL, C0, C0},
        '{C2, ET, ER, C0, C0, C0},
        '{C0, EB, ER, C2, ET, EL},
        '{C1, C2, ET, EB, C0, C0},
        '{C0, C1, C2, ET, EL, C0},
        '{C3, EL, ET, C0, C0, C0},
        '{C0, EB, ET, C3, C0, C0},
        '{C1, ER, ET, C3, EL, EB},
        '{C0, C1, ER, ET, C3, C0},
        '{C2, C3, EL, ER, C0, C0},
        '{C0, EB, ER, C2, C3, C0},
        '{C1, C2, C3, EL, EB, C0},
        '{C0, C0, C0, C0, C0, C0}
    };

    localparam int DRAIN_CYCLES   = 80;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_beat_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_beat_t             m_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_MASK_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // local copy of the register file
    logic [15:0] thr_q = 16'd32768;
    logic        fill_q = 1'b1;
    logic        diag_q = 1'b1;

    out_beat_t   expected_tris [$];
    int          error_count = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    logic        hold_off = 1'b0;
    int          quiet_cycles = 0;

    marching_squares_cell_triangulator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // interpolation along one edge, m0 at the lower endpoint
    function automatic logic [15:0] edge_frac(input logic [15:0] m0, input logic [15:0] m1);
        longint num;
        longint den;
        num = longint'(thr_q) - longint'(m0);
        den = longint'(m1) - longint'(m0);
        if (den == 0) return 16'd32768;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (num <= 0) return 16'd0;
        if (num >= den) return 16'hFFFF;
        return 16'((num << 16) / den);
    endfunction

    // work out the triangles a cell gives and queue them
    task automatic triangulate_cell(input in_beat_t c);
        logic [15:0] tv [8];
        logic [3:0]  pat;
        out_beat_t   tri_q;
        logic [VERT_W-1:0] va, vb, vc;
        int n;
        pat = {c.mask_01 >= thr_q, c.mask_11 >= thr_q, c.mask_10 >= thr_q,
               c.mask_00 >= thr_q};
        for (int i = 0; i < 4; i++) tv[i] = '0;
        tv[EB] = edge_frac(c.mask_00, c.mask_10);
        tv[ER] = edge_frac(c.mask_10, c.mask_11);
        tv[ET] = edge_frac(c.mask_01, c.mask_11);
        tv[EL] = edge_frac(c.mask_00, c.mask_01);
        if (pat == CASE_EMPTY) return;
        if (pat != CASE_FULL && !fill_q) return;
        n = (pat == CASE_FULL) ? 4 : OUTLINE_LEN[pat];
        for (int i = 1; i + 1 < n; i++) begin
            if (pat == CASE_FULL) begin
                // two halves, winding already flipped
                if (diag_q) begin
                    va = C0; vb = (i == 1) ? C2 : C3; vc = (i == 1) ? C1 : C2;
                end else begin
                    va = (i == 1) ? C0 : C1; vb = C3; vc = (i == 1) ? C1 : C2;
                end
            end else begin
                // fan from the first outline point, flipped winding
                va = OUTLINE[pat][0];
                vb = OUTLINE[pat][i + 1];
                vc = OUTLINE[pat][i];
            end
            tri_q.out_cell_x = c.cell_x;
            tri_q.out_cell_y = c.cell_y;
            tri_q.vert_a = va;
            tri_q.vert_b = vb;
            tri_q.vert_c = vc;
            tri_q.t_a = tv[va];
            tri_q.t_b = tv[vb];
            tri_q.t_c = tv[vc];
            tri_q.last = (i + 2 == n);
            expected_tris.push_back(tri_q);
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // result side: check each beat, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_tris.size() == 0) begin
                report("unexpected beat", 1, 0);
            end else begin
                out_beat_t w;
                w = expected_tris.pop_front();
                if (m_data.out_cell_x !== w.out_cell_x)
                    report("out_cell_x", m_data.out_cell_x, w.out_cell_x);
                if (m_data.out_cell_y !== w.out_cell_y)
                    report("out_cell_y", m_data.out_cell_y, w.out_cell_y);
                if (m_data.vert_a !== w.vert_a) report("vert_a", m_data.vert_a, w.vert_a);
                if (m_data.vert_b !== w.vert_b) report("vert_b", m_data.vert_b, w.vert_b);
                if (m_data.vert_c !== w.vert_c) report("vert_c", m_data.vert_c, w.vert_c);
                if (m_data.t_a !== w.t_a) report("t_a", m_data.t_a, w.t_a);
                if (m_data.t_b !== w.t_b) report("t_b", m_data.t_b, w.t_b);
                if (m_data.t_c !== w.t_c) report("t_c", m_data.t_c, w.t_c);
                if (m_data.last !== w.last) report("last", m_data.last, w.last);
            end
        end
        m_ready <= !hold_off && ($urandom_range(99) >= receiver_stall_pct);
    end

    // watchdog: cycles with no beat moving on either side and no config write
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("status: fail");
            $finish;
        end
    end

    // one cell beat; valid stays up into the next call when there is no gap
    task automatic send_cell(input in_beat_t c);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        triangulate_cell(c);
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (expected_tris.size() != 0) @(posedge aclk);
        // empty cells may still sit in the pipe
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_MASK_THRESHOLD) thr_q = val;
        else if (idx == REG_FILL_MIXED) fill_q = val[0];
        else if (idx == REG_DIAG_BL_TR) diag_q = val[0];
        @(posedge aclk);
    endtask

    task automatic set_regs(input logic [15:0] thr, input logic fill, input logic diag);
        write_reg(REG_MASK_THRESHOLD, thr);
        write_reg(REG_FILL_MIXED, {15'd0, fill});
        write_reg(REG_DIAG_BL_TR, {15'd0, diag});
        @(posedge aclk);
    endtask

    // masks chosen to land on both sides of the threshold and on it
    function automatic logic [15:0] pick_mask();
        case ($urandom_range(5))
            0: return 16'($urandom_range(65535));
            1: return thr_q;
            2: return thr_q - 16'd1;
            3: return 16'd0;
            4: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic in_beat_t rand_cell();
        in_beat_t c;
        c.cell_x  = 10'($urandom_range(1023));
        c.cell_y  = 10'($urandom_range(1023));
        c.mask_00 = pick_mask();
        c.mask_10 = pick_mask();
        c.mask_11 = pick_mask();
        c.mask_01 = pick_mask();
        return c;
    endfunction

    function automatic in_beat_t make_cell(input int x, input int y, input logic [15:0] a,
                                           input logic [15:0] b, input logic [15:0] d,
                                           input logic [15:0] e);
        in_beat_t c;
        c.cell_x = 10'(x); c.cell_y = 10'(y);
        c.mask_00 = a; c.mask_10 = b; c.mask_11 = d; c.mask_01 = e;
        return c;
    endfunction

    // every corner pattern at the reset settings, plus the edge cases
    task automatic test_directed();
        for (int p = 0; p < 16; p++)
            send_cell(make_cell(p, 1022 - p, p[0] ? 16'hFFFF : 16'd0,
                                p[1] ? 16'hFFFF : 16'd0, p[2] ? 16'hFFFF : 16'd0,
                                p[3] ? 16'hFFFF : 16'd0));
        // far end point lands exactly on the threshold: t saturates
        send_cell(make_cell(1023, 1023, 16'd0, 16'd32768, 16'd0, 16'd0));
        // all corners equal: full cell, corners only
        send_cell(make_cell(0, 0, 16'd40000, 16'd40000, 16'd40000, 16'd40000));
        // saddle with uneven samples
        send_cell(make_cell(512, 3, 16'd32768, 16'd100, 16'd65000, 16'd32767));
        send_cell(make_cell(3, 512, 16'd1, 16'd32769, 16'd2, 16'd50000));
        stop_sending();
        wait_drained();
    endtask

    // extremes and a few middles of all three registers
    task automatic test_register_sweep();
        logic [15:0] thr_list [4] = '{16'd0, 16'hFFFF, 16'd1, 16'd20000};
        for (int s = 0; s < 8; s++) begin
            set_regs(thr_list[s % 4], s[0] ^ s[2], s[1]);
            for (int i = 0; i < 12; i++) send_cell(rand_cell());
            stop_sending();
            wait_drained();
        end
        set_regs(16'($urandom_range(65535)), 1'b1, 1'b0);
    endtask

    // random cells under each idling mix
    task automatic test_flow_control();
        int send_mix [4]  = '{0, 60, 0, 27};
        int stall_mix [4] = '{0, 0, 60, 27};
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct    = send_mix[ph];
            receiver_stall_pct = stall_mix[ph];
            for (int i = 0; i < 30; i++) send_cell(rand_cell());
        end
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        stop_sending();
        wait_drained();
    endtask

    // receiver held off long enough for the input to stall
    task automatic test_backpressure();
        hold_off <= 1'b1;
        fork
            begin
                repeat (HOLD_OFF_LEN) @(posedge aclk);
                hold_off <= 1'b0;
            end
            for (int i = 0; i < 60; i++) send_cell(rand_cell());
        join
        stop_sending();
        // sender waits for every triangle before carrying on
        while (expected_tris.size() != 0) @(posedge aclk);
        receiver_stall_pct = 27;
        for (int i = 0; i < 15; i++) send_cell(rand_cell());
        stop_sending();
        receiver_stall_pct = 0;
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_register_sweep();
        test_flow_control();
        test_backpressure();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
